FILE: hdl/separable_gaussian_blur_7tap_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the separable Gaussian blur
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_GAUSSIAN_BLUR_7TAP_TOP_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_7TAP_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GB7_ASSERT_NOW(lbl, ck, rstn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (a) |-> (b)) \
		else $error("gb7 assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GB7_ASSERT_NEXT(lbl, ck, rstn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (a) |=> (b)) \
		else $error("gb7 assertion failed");

`endif

FILE: hdl/gb7_pkg.sv
// ----------------------------------------------------------------------------
// gb7_pkg
// Types and constants of the separable 7-tap Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none
package gb7_pkg;

	localparam int RADIUS = 3;
	localparam int TAPS   = 2 * RADIUS + 1;
	localparam int SLOTS  = 2 * RADIUS;
	localparam int PIX_W  = 8;
	localparam int COEF_W = 16;
	localparam int PROD_W = PIX_W + COEF_W;
	localparam int ACC_W  = PROD_W + 3;   // seven taps
	localparam int WSUM_W = COEF_W + 3;
	localparam int DIM_W  = 11;
	localparam int CIDX_W = 3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_COEF_CENTER  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_COEF_DIST1   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_COEF_DIST2   = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_COEF_DIST3   = 3'd5;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/gb7_ram.sv
// ----------------------------------------------------------------------------
// gb7_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module gb7_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/separable_gaussian_blur_7tap_top.sv
// One shared multiply-accumulate (seven taps per pass) and one 8-step restoring
// divider serve both passes; a new input is not taken until the item is done.
// A finished result that finds the previous one still waiting on m_tready holds
// the item until the output frees; a drain before the frame's last pixel is accepted and ignored.
// Reset: arst_n clears positions, window, output valid and restores register defaults.
// ----------------------------------------------------------------------------
// separable_gaussian_blur_7tap_top
// Horizontal then vertical 7-tap Gaussian over a raster pixel stream, with
// the six previous rows of horizontal results held in one line store RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module separable_gaussian_blur_7tap_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] pixel_in
	input  wire logic [0:0]  s_tuser,    // [0] action
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,    // [7:0] pixel_out
	output logic             m_tlast,    // frame_last
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CA = $clog2(MAX_WIDTH);
	localparam int RA = $clog2(MAX_HEIGHT);
	localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SW = $clog2(MAX_WIDTH * MAX_HEIGHT + gb7_pkg::RADIUS * MAX_WIDTH
		+ gb7_pkg::RADIUS + 1);
	localparam int PW = (WW > HW ? WW : HW) + 2;
	localparam int LW = gb7_pkg::SLOTS * gb7_pkg::PIX_W;

	gb7_pkg::state_t state_q, state_nx;

	// configuration
	logic [gb7_pkg::DIM_W-1:0]  width_q, height_q;
	logic [gb7_pkg::COEF_W-1:0] coef_q [4];

	// frame position
	logic [SW-1:0] s_q;
	logic [CA-1:0] hcol_q, ocol_q;
	logic [RA-1:0] orow_q;
	logic [2:0]    hslot_q, oslot_q;

	// item work registers
	logic [gb7_pkg::PIX_W-1:0]  window_q [gb7_pkg::TAPS];
	logic                       have_h_q, have_v_q, pass_v_q;
	logic [2:0]                 tap_q, bit_q;
	logic [gb7_pkg::ACC_W-1:0]  acc_q;
	logic [gb7_pkg::WSUM_W-1:0] wsum_q;
	logic [gb7_pkg::PIX_W-1:0]  quot_q, hv_q, vq_q;

	// derived frame geometry
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [NW-1:0] npix;
	logic [SW-1:0] out_lag, total;
	logic          s_lt_npix, ignore, accept, go, have_h, have_v, restart;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		npix    = NW'(w_eff) * NW'(h_eff);
		out_lag = (SW'(w_eff) << 1) + SW'(w_eff) + SW'(gb7_pkg::RADIUS);
		total   = SW'(npix) + out_lag;
		s_lt_npix = (s_q < SW'(npix));
		have_h  = (s_q >= SW'(gb7_pkg::RADIUS))
			&& ((s_q - SW'(gb7_pkg::RADIUS)) < SW'(npix));
		have_v  = (s_q >= out_lag);
	end

	// line store: one word per column, one byte per row slot
	logic          ram_we, ram_re;
	logic [CA-1:0] ram_raddr;
	logic [LW-1:0] ram_rdata, ram_wdata;

	gb7_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(hcol_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read-modify-write: replace the slot of the row just finished horizontally
	always_comb begin
		ram_wdata = ram_rdata;
		ram_wdata[hslot_q * gb7_pkg::PIX_W +: gb7_pkg::PIX_W] = hv_q;
	end

	// tap selection for the shared multiply-accumulate
	logic [2:0]                 tap_dist;
	logic [gb7_pkg::COEF_W-1:0] wt;
	logic [PW-1:0]              hpos, vpos;
	logic [3:0]                 slot_sum;
	logic [2:0]                 slot;
	logic [gb7_pkg::PIX_W-1:0]  tap_pix;
	logic                       tap_ok;
	logic [gb7_pkg::PROD_W-1:0] prod;

	always_comb begin
		tap_dist = (tap_q < 3'd3) ? (3'd3 - tap_q) : (tap_q - 3'd3);
		wt   = coef_q[tap_dist[1:0]];
		// position plus tap offset, biased by the radius
		hpos = PW'(hcol_q) + PW'(tap_q);
		vpos = PW'(orow_q) + PW'(tap_q);
		slot_sum = 4'(oslot_q) + 4'(tap_q) + 4'd3;
		if (slot_sum >= 4'd12) begin
			slot = 3'(slot_sum - 4'd12);
		end else if (slot_sum >= 4'd6) begin
			slot = 3'(slot_sum - 4'd6);
		end else begin
			slot = 3'(slot_sum);
		end
		if (pass_v_q) begin
			tap_ok = (vpos >= PW'(3)) && (vpos < PW'(h_eff) + PW'(3));
			if (tap_q == 3'd6) begin
				tap_pix = hv_q;
			end else begin
				tap_pix = ram_rdata[slot * gb7_pkg::PIX_W +: gb7_pkg::PIX_W];
			end
		end else begin
			tap_ok  = (hpos >= PW'(3)) && (hpos < PW'(w_eff) + PW'(3));
			tap_pix = window_q[3'd6 - tap_q];
		end
		prod = gb7_pkg::PROD_W'(tap_pix) * gb7_pkg::PROD_W'(wt);
	end

	// one restoring step of the divider
	logic [gb7_pkg::ACC_W-1:0] dsh;
	logic                      dge;
	logic [gb7_pkg::PIX_W-1:0] quot_nx, qres;

	always_comb begin
		dsh     = gb7_pkg::ACC_W'(wsum_q) << bit_q;
		dge     = (acc_q >= dsh);
		quot_nx = quot_q;
		quot_nx[bit_q] = dge;
		qres    = (wsum_q == '0) ? '0 : quot_nx;
	end

	// next state
	logic out_block;

	always_comb begin
		out_block = have_v_q && m_tvalid && !m_tready;
		state_nx  = state_q;
		case (state_q)
			gb7_pkg::ST_IDLE: begin
				if (go) state_nx = gb7_pkg::ST_TAP;
			end
			gb7_pkg::ST_TAP: begin
				if (tap_q == 3'd6) state_nx = gb7_pkg::ST_DIV;
			end
			gb7_pkg::ST_DIV: begin
				if (bit_q == 3'd0) state_nx = pass_v_q ? gb7_pkg::ST_DONE : gb7_pkg::ST_TAP;
			end
			gb7_pkg::ST_DONE: begin
				if (!out_block) state_nx = gb7_pkg::ST_IDLE;
			end
			default: state_nx = gb7_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	logic done_fire;

	always_comb begin
		s_tready  = (state_q == gb7_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		accept    = s_tvalid && s_tready;
		ignore    = s_tuser[0] && s_lt_npix;
		go        = accept && !ignore;
		done_fire = (state_q == gb7_pkg::ST_DONE) && !out_block;
		ram_re    = go;
		ram_raddr = have_v ? ocol_q : hcol_q;
		ram_we    = done_fire && have_h_q;
		restart   = (s_q + SW'(1)) >= total;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gb7_pkg::ST_IDLE;
			width_q  <= 11'd640;
			height_q <= 11'd480;
			coef_q[0] <= 16'd37348;
			coef_q[1] <= 16'd13460;
			coef_q[2] <= 16'd630;
			coef_q[3] <= 16'd4;
			s_q      <= '0;
			hcol_q   <= '0;
			hslot_q  <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			oslot_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_nx;
			// output register
			if (done_fire && have_v_q) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			// position update at the end of an item
			if (done_fire) begin
				if (restart) begin
					s_q     <= '0;
					hcol_q  <= '0;
					hslot_q <= '0;
					ocol_q  <= '0;
					orow_q  <= '0;
					oslot_q <= '0;
				end else begin
					s_q <= s_q + SW'(1);
					if (have_h_q) begin
						if (WW'(hcol_q) == w_eff - WW'(1)) begin
							hcol_q  <= '0;
							hslot_q <= (hslot_q == 3'd5) ? 3'd0 : hslot_q + 3'd1;
						end else begin
							hcol_q <= hcol_q + CA'(1);
						end
					end
					if (have_v_q) begin
						if (WW'(ocol_q) == w_eff - WW'(1)) begin
							ocol_q  <= '0;
							orow_q  <= orow_q + RA'(1);
							oslot_q <= (oslot_q == 3'd5) ? 3'd0 : oslot_q + 3'd1;
						end else begin
							ocol_q <= ocol_q + CA'(1);
						end
					end
				end
			end
			// configuration transaction; dimension writes restart the frame
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gb7_pkg::CFG_IMAGE_WIDTH,
					gb7_pkg::CFG_IMAGE_HEIGHT: begin
						if (cfg_index == gb7_pkg::CFG_IMAGE_WIDTH) begin
							width_q <= cfg_data[gb7_pkg::DIM_W-1:0];
						end else begin
							height_q <= cfg_data[gb7_pkg::DIM_W-1:0];
						end
						s_q     <= '0;
						hcol_q  <= '0;
						hslot_q <= '0;
						ocol_q  <= '0;
						orow_q  <= '0;
						oslot_q <= '0;
					end
					gb7_pkg::CFG_COEF_CENTER: coef_q[0] <= cfg_data;
					gb7_pkg::CFG_COEF_DIST1:  coef_q[1] <= cfg_data;
					gb7_pkg::CFG_COEF_DIST2:  coef_q[2] <= cfg_data;
					gb7_pkg::CFG_COEF_DIST3:  coef_q[3] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// window shift line, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gb7_pkg::TAPS; i++) window_q[i] <= '0;
		end else if (go) begin
			window_q[0] <= (!s_tuser[0] && s_lt_npix) ? s_tdata : '0;
			for (int i = 1; i < gb7_pkg::TAPS; i++) window_q[i] <= window_q[i-1];
		end
	end

	// datapath: two passes through one MAC and one divider
	always_ff @(posedge clk) begin
		case (state_q)
			gb7_pkg::ST_IDLE: begin
				if (go) begin
					have_h_q <= have_h;
					have_v_q <= have_v;
					pass_v_q <= 1'b0;
					tap_q    <= '0;
					acc_q    <= '0;
					wsum_q   <= '0;
				end
			end
			gb7_pkg::ST_TAP: begin
				if (tap_ok) begin
					acc_q  <= acc_q + gb7_pkg::ACC_W'(prod);
					wsum_q <= wsum_q + gb7_pkg::WSUM_W'(wt);
				end
				tap_q <= tap_q + 3'd1;
				bit_q <= 3'd7;
				quot_q <= '0;
			end
			gb7_pkg::ST_DIV: begin
				if (dge) acc_q <= acc_q - dsh;
				quot_q <= quot_nx;
				bit_q  <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					if (pass_v_q) begin
						vq_q <= qres;
					end else begin
						hv_q     <= have_h_q ? qres : '0;
						pass_v_q <= 1'b1;
						tap_q    <= '0;
						acc_q    <= '0;
						wsum_q   <= '0;
					end
				end
			end
			gb7_pkg::ST_DONE: begin
				if (done_fire && have_v_q) begin
					m_tdata <= vq_q;
					m_tlast <= (HW'(orow_q) == h_eff - HW'(1))
						&& (WW'(ocol_q) == w_eff - WW'(1));
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/gb7_checker.sv
// ----------------------------------------------------------------------------
// gb7_checker
// Port-level checks of the separable Gaussian blur, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "separable_gaussian_blur_7tap_top_macros.svh"
module gb7_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [0:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	logic pixel_taken;
	logic out_stall;

	assign pixel_taken = s_tvalid && s_tready && (s_tuser[0] == 1'b0);
	assign out_stall   = m_tvalid && !m_tready;

	// a stalled result holds its data and frame mark
	`GB7_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a pixel transaction always starts work, so the input closes next cycle
	`GB7_ASSERT_NEXT(a_pixel_busy, clk, arst_n, pixel_taken, !s_tready)

	// a new result only appears out of a busy period
	`GB7_ASSERT_NOW(a_out_from_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

	// configuration writes are never stalled
	`GB7_ASSERT_NOW(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind separable_gaussian_blur_7tap_top gb7_checker u_gb7_checker (.*);
`default_nettype wire

FILE: bench/separable_gaussian_blur_7tap_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for separable_gaussian_blur_7tap_top
// Drives pixel and drain transactions over small frames, reprograms the
// dimensions and kernel weights between frames, and checks every output
// pixel and its frame_last flag against a cycle-free predictor of the blur.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_7tap_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam bit ACT_PIXEL = 1'b0;
	localparam bit ACT_DRAIN = 1'b1;
	localparam int SETTLE = 64;

	// expected output pixel
	typedef struct packed {
		logic [7:0] pixel;
		logic       last;
	} blur_out_t;

	// blur predictor and result store
	class blur_scoreboard;
		int unsigned img_w, img_h;
		int unsigned coef[4];
		logic [7:0] row_win[gb7_pkg::TAPS];
		logic [7:0] line_mem[gb7_pkg::SLOTS * MAXW];
		int unsigned push_count;
		blur_out_t pending[$];
		int errors, checked;

		function new();
			img_w = 640;
			img_h = 480;
			coef = '{37348, 13460, 630, 4};
			foreach (row_win[i]) row_win[i] = '0;
			push_count = 0;
			errors = 0;
			checked = 0;
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned lim);
			if (v == 0) return 1;
			return (v > lim) ? lim : v;
		endfunction

		function void set_reg(logic [gb7_pkg::CIDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				gb7_pkg::CFG_IMAGE_WIDTH: begin
					img_w = 32'(val[10:0]);
					push_count = 0;
				end
				gb7_pkg::CFG_IMAGE_HEIGHT: begin
					img_h = 32'(val[10:0]);
					push_count = 0;
				end
				gb7_pkg::CFG_COEF_CENTER: coef[0] = 32'(val);
				gb7_pkg::CFG_COEF_DIST1:  coef[1] = 32'(val);
				gb7_pkg::CFG_COEF_DIST2:  coef[2] = 32'(val);
				gb7_pkg::CFG_COEF_DIST3:  coef[3] = 32'(val);
				default: ;
			endcase
		endfunction

		// one accepted input transaction
		function void note_input(bit act, logic [7:0] px);
			int unsigned w, h, npix, lag, total, s, idx, hr, hc, hv, k, r, c;
			int unsigned acc, ws, wt, v;
			int col, row;
			bit have_h;
			blur_out_t e;
			w = clamp_dim(img_w, MAXW);
			h = clamp_dim(img_h, MAXH);
			npix = w * h;
			lag = gb7_pkg::RADIUS + gb7_pkg::RADIUS * w;
			total = npix + lag;
			s = push_count;
			have_h = 0;
			hv = 0;
			if (act == ACT_DRAIN && s < npix) return;
			for (int i = gb7_pkg::TAPS - 1; i > 0; i--) row_win[i] = row_win[i-1];
			row_win[0] = (act == ACT_PIXEL && s < npix) ? px : 8'd0;
			// horizontal pass
			if (s >= gb7_pkg::RADIUS && s - gb7_pkg::RADIUS < npix) begin
				idx = s - gb7_pkg::RADIUS;
				hr = idx / w;
				hc = idx % w;
				acc = 0;
				ws = 0;
				for (int d = -gb7_pkg::RADIUS; d <= gb7_pkg::RADIUS; d++) begin
					col = int'(hc) + d;
					if (col >= 0 && col < int'(w)) begin
						wt = coef[d < 0 ? -d : d];
						acc += row_win[gb7_pkg::RADIUS - d] * wt;
						ws += wt;
					end
				end
				hv = ws ? (acc / ws) & 8'hFF : 0;
				have_h = 1;
			end
			// vertical pass
			if (s >= lag) begin
				k = s - lag;
				r = k / w;
				c = k % w;
				acc = 0;
				ws = 0;
				for (int d = -gb7_pkg::RADIUS; d <= gb7_pkg::RADIUS; d++) begin
					row = int'(r) + d;
					if (row >= 0 && row < int'(h)) begin
						wt = coef[d < 0 ? -d : d];
						v = (d == gb7_pkg::RADIUS) ? hv
							: line_mem[(row % gb7_pkg::SLOTS) * MAXW + c];
						acc += v * wt;
						ws += wt;
					end
				end
				e.pixel = 8'(ws != 0 ? acc / ws : 0);
				e.last = (k == npix - 1);
				pending = {pending, e};
			end
			if (have_h) line_mem[(hr % gb7_pkg::SLOTS) * MAXW + hc] = hv[7:0];
			push_count = s + 1;
			if (push_count >= total) push_count = 0;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// one accepted output transaction
		task check_result(logic [7:0] px, logic last);
			blur_out_t e;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected output pixel %0d last %0b", px, last));
				return;
			end
			e = pending.pop_front();
			if (px !== e.pixel)
				report($sformatf("pixel_out %0d, expected %0d", px, e.pixel));
			if (last !== e.last)
				report($sformatf("frame_last %0b, expected %0b", last, e.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	blur_scoreboard sb = new();
	int items_sent = 0;
	int frames_done = 0;
	int src_idle_pct = 13;
	int snk_idle_pct = 47;

	separable_gaussian_blur_7tap_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

	// output monitor
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);

	// idling schedule follows the item count
	always @(posedge clk) begin
		if (items_sent >= 1260) begin
			src_idle_pct <= 0;
			snk_idle_pct <= 0;
		end else if (items_sent >= 630) begin
			src_idle_pct <= 47;
			snk_idle_pct <= 13;
		end
	end

	task send_item(bit act, logic [7:0] px);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = px;
		do @(posedge clk); while (!s_tready);
		sb.note_input(act, px);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// wait for all results plus the block's own pipeline
	task wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task set_dims(int unsigned w, int unsigned h);
		write_reg(gb7_pkg::CFG_IMAGE_WIDTH, 16'(w));
		write_reg(gb7_pkg::CFG_IMAGE_HEIGHT, 16'(h));
	endtask

	task set_weights(int unsigned c0, int unsigned c1, int unsigned c2, int unsigned c3);
		write_reg(gb7_pkg::CFG_COEF_CENTER, 16'(c0));
		write_reg(gb7_pkg::CFG_COEF_DIST1, 16'(c1));
		write_reg(gb7_pkg::CFG_COEF_DIST2, 16'(c2));
		write_reg(gb7_pkg::CFG_COEF_DIST3, 16'(c3));
	endtask

	// full frame plus flush; noise adds early drains and late pixels
	task run_frame(int unsigned w, int unsigned h, bit noisy);
		int unsigned ew, eh;
		ew = sb.clamp_dim(w, MAXW);
		eh = sb.clamp_dim(h, MAXH);
		for (int i = 0; i < ew * eh; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
			send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < gb7_pkg::RADIUS * ew + gb7_pkg::RADIUS; i++)
			send_item((noisy && $urandom_range(0, 4) == 0) ? ACT_PIXEL : ACT_DRAIN,
				8'($urandom_range(0, 255)));
		wait_idle();
		frames_done++;
	endtask

	initial begin
		int unsigned w, h;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: early drain on a fresh frame, then a 1x1 frame
		set_dims(1, 1);
		send_item(ACT_DRAIN, 8'hA5);
		send_item(ACT_PIXEL, 8'hFF);
		for (int i = 0; i < 2 * gb7_pkg::RADIUS; i++) send_item(ACT_DRAIN, 8'h5A);
		wait_idle();
		// zero dimensions act as one, zero weights give zero
		set_dims(0, 0);
		set_weights(0, 0, 0, 0);
		send_item(ACT_PIXEL, 8'h00);
		for (int i = 0; i < 2 * gb7_pkg::RADIUS; i++) send_item(ACT_PIXEL, 8'hFF);
		wait_idle();
		// oversized width and height saturate; abort the frame partway through
		set_weights(65535, 65535, 65535, 65535);
		set_dims(2047, 2047);
		for (int i = 0; i < 8; i++) send_item(ACT_PIXEL, (i & 1) ? 8'hFF : 8'h00);
		wait_idle();
		set_dims(3, 2);
		run_frame(3, 2, 0);

		// random frames, mostly small
		while (items_sent < 1900) begin
			case ($urandom_range(0, 5))
				0: set_weights(37348, 13460, 630, 4);
				1: set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				2: set_weights(65535, 0, 65535, 0);
				default: ;
			endcase
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			set_dims(w, h);
			if ($urandom_range(0, 9) == 0) begin
				// partial frame, aborted by the next dimension write
				for (int i = 0; i < $urandom_range(1, w * h); i++)
					send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
				wait_idle();
			end else begin
				run_frame(w, h, $urandom_range(0, 2) == 0);
			end
		end

		wait_idle();
		$display("Covered %0d input transactions over %0d frames, %0d outputs checked.",
			items_sent, frames_done, sb.checked);
		if (sb.errors == 0)
			$display("PASS separable_gaussian_blur_7tap_top");
		else
			$display("FAIL separable_gaussian_blur_7tap_top");
		$finish;
	end

	// run limit
	initial begin
		#30ms;
		$display("Timeout with %0d results outstanding.", sb.pending.size());
		$display("FAIL separable_gaussian_blur_7tap_top");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/gb7_pkg.sv
hdl/gb7_ram.sv
hdl/separable_gaussian_blur_7tap_top.sv
hdl/gb7_checker.sv
bench/separable_gaussian_blur_7tap_top_tb.sv
